@@ rtl/core/psu_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared constants, filter codes, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package psu_pkg;

	localparam int MAX_ROW_PIXELS  = 4096;
	localparam int MAX_PIXEL_BYTES = 4;
	localparam int STORE_DEPTH     = MAX_ROW_PIXELS * MAX_PIXEL_BYTES;
	localparam int STORE_AW        = $clog2(STORE_DEPTH);
	localparam int COL_W           = $clog2(STORE_DEPTH + 1);
	localparam int LANE_W          = $clog2(MAX_PIXEL_BYTES);

	localparam int PIX_W      = 13;
	localparam int BPP_W      = 3;
	localparam int ROWS_W     = 16;
	localparam int ROW_LEN_W  = PIX_W + BPP_W;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [PIX_W-1:0]  RESET_ROW_PIXELS  = PIX_W'(1);
	localparam logic [BPP_W-1:0]  RESET_PIXEL_BYTES = BPP_W'(4);
	localparam logic [ROWS_W-1:0] RESET_IMAGE_ROWS  = ROWS_W'(1);

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_PIXELS  = 2'd0,
		REG_PIXEL_BYTES = 2'd1,
		REG_IMAGE_ROWS  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_ERROR  = 1'b1
	} kind_t;

	// One classified item on its way from the front end to the back end.
	typedef struct packed {
		kind_t                kind;
		logic [BYTE_W-1:0]    data;
		logic [STORE_AW-1:0]  addr;
		logic [LANE_W-1:0]    lane;
		logic                 use_left;
		logic                 has_above;
		filt_t                filt;
		logic                 row_end;
		logic                 image_end;
	} entry_t;

endpackage

@@ rtl/core/psu_if.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter channels
// Valid/ready channels for filtered bytes, rebuilt bytes and register writes.
// ----------------------------------------------------------------------------
interface psu_in_if import psu_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface psu_out_if import psu_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              row_end;
	logic              image_end;
	logic              bad_filter;

	modport source (output valid, output out_byte, output row_end, output image_end,
		output bad_filter, input ready);
	modport sink (input valid, input out_byte, input row_end, input image_end,
		input bad_filter, output ready);
endinterface

interface psu_cfg_if import psu_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/psu_front.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter front end
// Holds the registers, tracks row position and filter type, classifies items.
// ----------------------------------------------------------------------------
module psu_front import psu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	psu_in_if.sink       filtered,
	psu_cfg_if.sink      cfg,
	output logic         push_valid,
	input  logic         push_ready,
	output entry_t       push_entry
);

	logic [PIX_W-1:0]     row_pixels_q;
	logic [BPP_W-1:0]     pixel_bytes_q;
	logic [ROWS_W-1:0]    image_rows_q;

	logic [COL_W-1:0]     col_q;
	logic [ROWS_W-1:0]    row_count_q;
	logic                 err_q;
	filt_t                filt_q;
	logic [1:0]           s3_q;

	logic [PIX_W-1:0]     eff_pix;
	logic [BPP_W-1:0]     eff_bpp;
	logic [ROWS_W-1:0]    eff_rows;
	logic [ROW_LEN_W-1:0] row_len;
	logic [COL_W-1:0]     s;
	logic [ROWS_W:0]      rows_next;
	logic                 at_filter;
	logic                 bad_code;
	logic                 row_end;
	logic                 image_end;
	logic [LANE_W-1:0]    lane;
	logic                 acc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q  <= RESET_ROW_PIXELS;
			pixel_bytes_q <= RESET_PIXEL_BYTES;
			image_rows_q  <= RESET_IMAGE_ROWS;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ROW_PIXELS:  row_pixels_q  <= cfg.data[PIX_W-1:0];
				REG_PIXEL_BYTES: pixel_bytes_q <= cfg.data[BPP_W-1:0];
				REG_IMAGE_ROWS:  image_rows_q  <= cfg.data[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (row_pixels_q == '0)
			eff_pix = PIX_W'(1);
		else if (row_pixels_q > PIX_W'(MAX_ROW_PIXELS))
			eff_pix = PIX_W'(MAX_ROW_PIXELS);
		else
			eff_pix = row_pixels_q;

		if (pixel_bytes_q == '0)
			eff_bpp = BPP_W'(1);
		else if (pixel_bytes_q > BPP_W'(MAX_PIXEL_BYTES))
			eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
		else
			eff_bpp = pixel_bytes_q;

		eff_rows = (image_rows_q == '0) ? ROWS_W'(1) : image_rows_q;
	end

	assign row_len   = ROW_LEN_W'(eff_pix) * ROW_LEN_W'(eff_bpp);
	assign s         = col_q - COL_W'(1);
	assign at_filter = (col_q == '0);
	assign bad_code  = filtered.in_byte > BYTE_W'(FILT_PAETH);
	assign row_end   = !at_filter && (ROW_LEN_W'(col_q) >= row_len);
	assign rows_next = {1'b0, row_count_q} + (ROWS_W + 1)'(1);
	assign image_end = row_end && (rows_next >= {1'b0, eff_rows});

	// Three bytes per pixel needs the column modulo three, kept as a counter.
	always_comb begin
		case (eff_bpp)
			3'd2:    lane = LANE_W'(s[0]);
			3'd3:    lane = s3_q;
			3'd4:    lane = s[LANE_W-1:0];
			default: lane = '0;
		endcase
	end

	always_comb begin
		if (at_filter)
			push_valid = filtered.valid && !err_q && bad_code;
		else
			push_valid = filtered.valid && (!err_q || image_end);

		push_entry.kind      = (at_filter || err_q) ? KIND_ERROR : KIND_SAMPLE;
		push_entry.data      = filtered.in_byte;
		push_entry.addr      = s[STORE_AW-1:0];
		push_entry.lane      = lane;
		push_entry.use_left  = (s >= COL_W'(eff_bpp));
		push_entry.has_above = (row_count_q != '0);
		push_entry.filt      = filt_q;
		push_entry.row_end   = row_end;
		push_entry.image_end = image_end;
	end

	assign filtered.ready = push_ready;
	assign acc            = filtered.valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_count_q <= '0;
			err_q       <= 1'b0;
			filt_q      <= FILT_NONE;
			s3_q        <= '0;
		end else if (acc) begin
			if (at_filter) begin
				col_q <= COL_W'(1);
				s3_q  <= '0;
				if (!err_q) begin
					if (bad_code)
						err_q <= 1'b1;
					else
						filt_q <= filt_t'(filtered.in_byte[2:0]);
				end
			end else begin
				if (row_end) begin
					col_q <= '0;
					s3_q  <= '0;
					if (image_end) begin
						row_count_q <= '0;
						err_q       <= 1'b0;
						filt_q      <= FILT_NONE;
					end else begin
						row_count_q <= row_count_q + ROWS_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
					s3_q  <= (s3_q == 2'd2) ? 2'd0 : s3_q + 2'd1;
				end
			end
		end
	end

endmodule

@@ rtl/core/psu_queue.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter queue
// Small first-in first-out buffer of classified items between the two ends.
// ----------------------------------------------------------------------------
module psu_queue import psu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  entry_t push_entry,
	output logic   head_valid,
	output entry_t head_entry,
	input  logic   head_pop
);

	entry_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QUEUE_AW + 1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW + 1)'(1);
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/psu_back.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter back end
// Reads the prior row, rebuilds each byte and drives the output register.
// ----------------------------------------------------------------------------
module psu_back import psu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  entry_t   head_entry,
	output logic     head_pop,
	psu_out_if.source pixels
);

	logic [BYTE_W-1:0] mem [STORE_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;
	logic              fwd_s1;
	logic [BYTE_W-1:0] last_recon_q;

	logic              valid_s1;
	entry_t            ent_s1;

	logic [BYTE_W-1:0] left_q   [MAX_PIXEL_BYTES];
	logic [BYTE_W-1:0] upleft_q [MAX_PIXEL_BYTES];

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              row_end_q;
	logic              image_end_q;
	logic              bad_q;

	logic              advance;
	logic              retire;
	logic              wr_en;
	logic [BYTE_W-1:0] a;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] c;
	logic signed [9:0] p;
	logic signed [9:0] da;
	logic signed [9:0] db;
	logic signed [9:0] dc;
	logic [9:0]        pa;
	logic [9:0]        pb;
	logic [9:0]        pc;
	logic [BYTE_W-1:0] paeth;
	logic [BYTE_W-1:0] avg;
	logic [BYTE_W-1:0] pred;
	logic [BYTE_W-1:0] recon;

	assign advance  = !out_valid_q || pixels.ready;
	assign head_pop = advance && head_valid;
	assign retire   = advance && valid_s1;
	assign wr_en    = retire && (ent_s1.kind == KIND_SAMPLE);

	// The store reads old data when the retiring item writes the same entry, so
	// that case takes the byte just written instead.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[ent_s1.addr] <= recon;
		if (head_pop)
			rd_data_q <= mem[head_entry.addr];
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			ent_s1 <= head_entry;
			fwd_s1 <= wr_en && (ent_s1.addr == head_entry.addr);
		end
		if (wr_en)
			last_recon_q <= recon;
	end

	always_comb begin
		if (!ent_s1.has_above)
			b = '0;
		else if (fwd_s1)
			b = last_recon_q;
		else
			b = rd_data_q;
		a = ent_s1.use_left ? left_q[ent_s1.lane] : '0;
		c = (ent_s1.use_left && ent_s1.has_above) ? upleft_q[ent_s1.lane] : '0;

		p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
		da = p - $signed({2'b00, a});
		db = p - $signed({2'b00, b});
		dc = p - $signed({2'b00, c});
		pa = da[9] ? 10'(-da) : 10'(da);
		pb = db[9] ? 10'(-db) : 10'(db);
		pc = dc[9] ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc)
			paeth = a;
		else if (pb <= pc)
			paeth = b;
		else
			paeth = c;

		avg = BYTE_W'(((BYTE_W + 1)'(a) + (BYTE_W + 1)'(b)) >> 1);

		case (ent_s1.filt)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = avg;
			FILT_PAETH: pred = paeth;
			default:    pred = '0;
		endcase
		recon = ent_s1.data + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i]   <= '0;
				upleft_q[i] <= '0;
			end
		end else begin
			if (advance)
				valid_s1 <= head_valid;
			// A finished image leaves no neighbours behind for the next one.
			if (retire && ent_s1.image_end) begin
				for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i]   <= '0;
					upleft_q[i] <= '0;
				end
			end else if (wr_en) begin
				left_q[ent_s1.lane]   <= recon;
				upleft_q[ent_s1.lane] <= b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			out_byte_q  <= (ent_s1.kind == KIND_SAMPLE) ? recon : '0;
			row_end_q   <= ent_s1.row_end;
			image_end_q <= ent_s1.image_end;
			bad_q       <= (ent_s1.kind == KIND_ERROR);
		end
	end

	assign pixels.valid      = out_valid_q;
	assign pixels.out_byte   = out_byte_q;
	assign pixels.row_end    = row_end_q;
	assign pixels.image_end  = image_end_q;
	assign pixels.bad_filter = bad_q;

endmodule

@@ rtl/core/png_scanline_unfilter.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Rebuilds PNG scanlines from the inflated stream, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// The filtered channel takes the inflated image one byte per item: the filter
// type at the start of each row, then the row's samples. The pixels channel
// returns one rebuilt byte per sample with row and image end marks; a filter
// byte yields nothing. An unknown filter type yields one flagged item, then
// nothing until the image's last byte, which yields a flagged closing item.
// The cfg channel writes row_pixels (index 0), pixel_bytes (1) and
// image_rows (2); it is always ready. The user must write it only while the
// block is idle; the block itself does not enforce this.
// With the queue empty, an accepted byte enters the queue, then moves into
// the store-read stage and from there loads the output register, which
// offers the result. The block takes one byte every cycle while the queue
// has room to take it; the prior-row store gives
// one read and one write each cycle, which is just what that rate needs.
// When the receiver stalls, the output register holds and the back end
// stops, while the four-entry queue keeps the front end taking bytes until
// it fills. Reset clears the position counters, the neighbour bytes and the
// queue and loads the register defaults; the prior-row store is not cleared
// and needs no clearing pass, since each row is written before it is read.
// ----------------------------------------------------------------------------
module png_scanline_unfilter import psu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	psu_in_if.sink     filtered,
	psu_out_if.source  pixels,
	psu_cfg_if.sink    cfg
);

	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   head_valid;
	entry_t head_entry;
	logic   head_pop;

	psu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.filtered   (filtered),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	psu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.head_pop   (head_pop)
	);

	psu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.head_pop   (head_pop),
		.pixels     (pixels)
	);

endmodule

@@ tb/png_scanline_unfilter_tb.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Feeds filtered image streams under several row and pixel settings, predicts
// every rebuilt byte and compares the pixel items in order as they arrive.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_tb import psu_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT      = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 8;
	localparam int RANDOM_ITEMS    = 800;

	// Smallest filter byte that is not a known filter type.
	localparam logic [7:0] FILT_FIRST_BAD = 8'd5;

	typedef struct packed {
		bit [7:0] data;
		bit       row_end;
		bit       image_end;
		bit       bad_filter;
	} pixel_t;

	class unfilter_scoreboard;
		bit [PIX_W-1:0]  row_pixels;
		bit [BPP_W-1:0]  pixel_bytes;
		bit [ROWS_W-1:0] image_rows;
		bit [7:0]        prior_row [STORE_DEPTH];
		bit [7:0]        left_px [MAX_PIXEL_BYTES];
		bit [7:0]        upleft_px [MAX_PIXEL_BYTES];
		filt_t           row_filt;
		int unsigned     column;
		bit [15:0]       rows_done;
		bit              error_seen;
		pixel_t          pending_pixels [$];
		int              mismatches;

		function new();
			row_pixels  = RESET_ROW_PIXELS;
			pixel_bytes = RESET_PIXEL_BYTES;
			image_rows  = RESET_IMAGE_ROWS;
			mismatches  = 0;
			start_image();
		endfunction

		function void start_image();
			foreach (left_px[i]) begin
				left_px[i]   = 8'd0;
				upleft_px[i] = 8'd0;
			end
			row_filt   = FILT_NONE;
			column     = 0;
			rows_done  = 16'd0;
			error_seen = 1'b0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] value);
			case (idx)
				REG_ROW_PIXELS: row_pixels = value[PIX_W-1:0];
				REG_PIXEL_BYTES: pixel_bytes = value[BPP_W-1:0];
				REG_IMAGE_ROWS: image_rows = value[ROWS_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_pixels();
			if (row_pixels == 0) return 1;
			if (row_pixels > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
			return 32'(row_pixels);
		endfunction

		function int unsigned eff_bpp();
			if (pixel_bytes == 0) return 1;
			if (pixel_bytes > MAX_PIXEL_BYTES) return MAX_PIXEL_BYTES;
			return 32'(pixel_bytes);
		endfunction

		function int unsigned eff_rows();
			return (image_rows == 0) ? 1 : 32'(image_rows);
		endfunction

		function bit [7:0] paeth_pick(bit [7:0] a, bit [7:0] b, bit [7:0] c);
			int p, pa, pb, pc;
			p  = int'(a) + int'(b) - int'(c);
			pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
			pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
			pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
			if (pa <= pb && pa <= pc) return a;
			if (pb <= pc) return b;
			return c;
		endfunction

		// Works out the pixel item, if any, that one accepted filtered byte causes.
		function void accept_filtered(bit [7:0] in_byte);
			int unsigned bpp, row_len, s, lane;
			bit          rend, iend;
			bit [15:0]   this_row;
			bit [7:0]    a, b, c, recon;
			bit [8:0]    sum9;
			pixel_t      px;
			bpp     = eff_bpp();
			row_len = eff_pixels() * bpp;
			if (column == 0) begin
				column = 1;
				if (error_seen) return;
				if (in_byte > 8'(FILT_PAETH)) begin
					error_seen = 1'b1;
					px = '{8'd0, 1'b0, 1'b0, 1'b1};
					pending_pixels.push_back(px);
					return;
				end
				row_filt = filt_t'(in_byte[2:0]);
				return;
			end
			s    = column - 1;
			rend = (s + 1 >= row_len);
			iend = rend && (int'(rows_done) + 1 >= eff_rows());
			if (rend) begin
				column    = 0;
				rows_done = rows_done + 16'd1;
			end else begin
				column = column + 1;
			end
			if (error_seen) begin
				if (!iend) return;
				start_image();
				px = '{8'd0, 1'b1, 1'b1, 1'b1};
				pending_pixels.push_back(px);
				return;
			end
			lane     = s % bpp;
			this_row = rend ? rows_done - 16'd1 : rows_done;
			b        = (this_row != 0) ? prior_row[s[STORE_AW-1:0]] : 8'd0;
			a        = (s >= bpp) ? left_px[lane[LANE_W-1:0]] : 8'd0;
			c        = (s >= bpp && this_row != 0) ? upleft_px[lane[LANE_W-1:0]] : 8'd0;
			sum9     = {1'b0, a} + {1'b0, b};
			case (row_filt)
				FILT_SUB: recon = in_byte + a;
				FILT_UP: recon = in_byte + b;
				FILT_AVG: recon = in_byte + sum9[8:1];
				FILT_PAETH: recon = in_byte + paeth_pick(a, b, c);
				default: recon = in_byte;
			endcase
			left_px[lane[LANE_W-1:0]]   = recon;
			upleft_px[lane[LANE_W-1:0]] = b;
			prior_row[s[STORE_AW-1:0]]  = recon;
			if (iend) start_image();
			px = '{recon, rend, iend, 1'b0};
			pending_pixels.push_back(px);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				$error("pixel item arrived with none expected: out_byte %0d", got.data);
				mismatches++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got.data !== want.data) begin
				$error("out_byte: expected %0d, got %0d", want.data, got.data);
				mismatches++;
			end
			if (got.row_end !== want.row_end) begin
				$error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
				mismatches++;
			end
			if (got.image_end !== want.image_end) begin
				$error("image_end: expected %0d, got %0d", want.image_end, got.image_end);
				mismatches++;
			end
			if (got.bad_filter !== want.bad_filter) begin
				$error("bad_filter: expected %0d, got %0d", want.bad_filter, got.bad_filter);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	psu_in_if  filtered_ch ();
	psu_out_if pixel_ch ();
	psu_cfg_if cfg_ch ();

	png_scanline_unfilter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.filtered (filtered_ch),
		.pixels   (pixel_ch),
		.cfg      (cfg_ch)
	);

	unfilter_scoreboard sb;
	int burst_left = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	bit hold_off_request = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && pixel_ch.valid && pixel_ch.ready) begin
			sb.check_pixel('{pixel_ch.out_byte, pixel_ch.row_end, pixel_ch.image_end,
				pixel_ch.bad_filter});
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((filtered_ch.valid && filtered_ch.ready) || (pixel_ch.valid && pixel_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("png_scanline_unfilter_tb failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Receiver: spans of steady, light, heavy or no back-pressure, plus one long
	// hold-off on request so that the queue fills and the input stalls.
	initial begin : receiver
		int shape;
		int span;
		pixel_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				repeat (HOLD_OFF_CYCLES) begin
					@(negedge clk);
					pixel_ch.ready <= 1'b0;
				end
			end
			shape = $urandom_range(0, 3);
			span  = $urandom_range(5, 60);
			repeat (span) begin
				@(negedge clk);
				case (shape)
					0: pixel_ch.ready <= 1'b1;
					1: pixel_ch.ready <= ($urandom_range(0, 3) != 0);
					2: pixel_ch.ready <= 1'($urandom_range(0, 1));
					default: pixel_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] value);
		@(negedge clk);
		if (burst_left == 0) begin
			filtered_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		filtered_ch.valid   <= 1'b1;
		filtered_ch.in_byte <= value;
		do @(posedge clk); while (!filtered_ch.ready);
		sb.accept_filtered(value);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, value);
	endtask

	task automatic set_config(input logic [15:0] px, input logic [15:0] bpp,
			input logic [15:0] rows);
		write_reg(REG_ROW_PIXELS, px);
		write_reg(REG_PIXEL_BYTES, bpp);
		write_reg(REG_IMAGE_ROWS, rows);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Waits until every predicted pixel item has come, then lets the pipeline
	// settle, since dropped bytes may still be in flight.
	task automatic drain();
		@(negedge clk);
		filtered_ch.valid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] sample_value(input int shape);
		case (shape)
			0: return 8'($urandom_range(0, 255));
			1: begin
				case ($urandom_range(0, 5))
					0: return 8'd0;
					1: return 8'd1;
					2: return 8'd127;
					3: return 8'd128;
					4: return 8'd254;
					default: return 8'd255;
				endcase
			end
			default: return ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
				: 8'($urandom_range(252, 255));
		endcase
	endfunction

	// Sends one whole image for the current settings; each row's filter byte is
	// an unknown type with the given chance per thousand.
	task automatic send_image(input int bad_per_mille);
		int unsigned n_rows;
		int unsigned row_len;
		int          shape;
		logic [7:0]  filt_byte;
		n_rows  = sb.eff_rows();
		row_len = sb.eff_pixels() * sb.eff_bpp();
		shape   = $urandom_range(0, 2);
		for (int r = 0; r < n_rows; r++) begin
			if ($urandom_range(0, 999) < bad_per_mille)
				filt_byte = 8'($urandom_range(FILT_FIRST_BAD, 255));
			else
				filt_byte = 8'($urandom_range(FILT_NONE, FILT_PAETH));
			send_byte(filt_byte);
			for (int i = 0; i < row_len; i++) send_byte(sample_value(shape));
		end
	endtask

	initial begin : stimulus
		logic [7:0]  filters_walk [15];
		int          random_start;
		int unsigned px;
		arst_n              = 1'b0;
		filtered_ch.valid   = 1'b0;
		filtered_ch.in_byte = 8'd0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_ROW_PIXELS;
		cfg_ch.data         = 16'd0;
		sb = new();
		filters_walk = '{8'(FILT_SUB), 8'd255, 8'd1, 8'(FILT_UP), 8'd0, 8'd255,
			8'(FILT_AVG), 8'd255, 8'd255, 8'(FILT_PAETH), 8'd1, 8'd0,
			8'(FILT_PAETH), 8'd128, 8'd255};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings, one row of one four-byte pixel, with the top unknown type.
		send_byte(8'd255);
		send_byte(8'd0);
		send_byte(8'd255);
		send_byte(8'd1);
		send_byte(8'd128);
		drain();

		// Zero in every register acts as one.
		set_config(16'd0, 16'd0, 16'd0);
		send_byte(FILT_FIRST_BAD);
		send_byte(8'd77);
		send_byte(8'(FILT_NONE));
		send_byte(8'd255);
		drain();

		// Every filter type but None on a two-pixel row, with edge byte values.
		set_config(16'd2, 16'd1, 16'd5);
		foreach (filters_walk[i]) send_byte(filters_walk[i]);
		drain();

		// Row shortened part way along: the next sample closes the row.
		set_config(16'(MAX_ROW_PIXELS), 16'd1, 16'd2);
		send_byte(8'(FILT_SUB));
		send_byte(8'd3);
		send_byte(8'd250);
		send_byte(8'd0);
		send_byte(8'd255);
		send_byte(8'd9);
		drain();
		write_reg(REG_ROW_PIXELS, 16'd3);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		send_byte(8'd44);
		send_byte(8'(FILT_UP));
		send_byte(8'd200);
		send_byte(8'd100);
		send_byte(8'd7);
		drain();

		// Image shortened below the rows already done: the next row end closes it.
		set_config(16'd1, 16'd1, 16'd65535);
		send_byte(8'(FILT_NONE));
		send_byte(8'd10);
		send_byte(8'(FILT_AVG));
		send_byte(8'd20);
		drain();
		write_reg(REG_IMAGE_ROWS, 16'd1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		send_byte(8'(FILT_PAETH));
		send_byte(8'd30);
		drain();

		// Random settings on small images, with junk in the unused register bits.
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_ITEMS) begin
			px = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 6);
			set_config({3'($urandom_range(0, 7)), 13'(px)},
				{13'($urandom), 3'($urandom_range(0, 7))},
				16'($urandom_range(0, 5)));
			repeat ($urandom_range(1, 3)) send_image(40);
			drain();
		end

		// Pixel size register above range on a two-row image, while the receiver
		// holds off for a long stretch so that the queue fills and the input stalls.
		set_config(16'd20, 16'd7, 16'd2);
		hold_off_request = 1'b1;
		send_image(0);
		drain();

		if (sb.mismatches == 0) begin
			$display("png_scanline_unfilter_tb passed");
		end else begin
			$display("png_scanline_unfilter_tb failed");
		end
		$finish;
	end

endmodule
